// File: design/bpct_pkg.sv
`timescale 1ns / 1ps

package bpct_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int TIME_BITS   = 16;

  // occupancy count holds 0..TABLE_DEPTH
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic OP_BLOCK = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [1:0] ST_ACCEPT = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_TICK   = 2'd2;

  typedef struct packed {
    logic                 used;
    logic [ID_BITS-1:0]   id;
    logic [TIME_BITS-1:0] cnt;
    logic                 credit;
  } entry_t;

  // ins: shift toward tail (new entry at head)
  // adv: shift toward head; tail cell loads the recycled entry
  typedef struct packed {
    logic ins;
    logic adv;
    logic tail;
  } cell_ctl_t;

endpackage

// File: design/blocked_process_countdown_table.sv
`timescale 1ns / 1ps

// Blocked-process countdown table. Entries live in a row of cells kept in
// age order, newest in cell 0, always packed from cell 0 with no holes.
// A block item shifts the row one cell toward the tail and writes the new
// entry into cell 0 (or answers "full" when all cells are used), and gives
// one result. A tick item walks the row through the head cell: each cycle
// in which the output can take a result, the head entry is decremented
// (saturating at zero) and either released, when its count is zero and it
// has credit, or put back behind the last occupied cell, so the order
// survives and the row stays packed. A tick thus goes through its
// acceptance, the walk over the occupied entries and the loading of the
// final result, and is held up when the output is held off. Releases go out
// newest first; one release is held back so the final one can carry tlast.
// A tick that releases nothing gives one empty result with tlast set.
module blocked_process_countdown_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // process_id[7:0], wait_ticks[23:8], has_credit[24]
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // released_id[7:0]
  output logic [2:0]  out_tuser,  // status[1:0], released_valid[2]
  output logic        out_tlast
);
  import bpct_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;     // occupied cells
  logic [CNT_W-1:0] steps_r, steps_nxt;   // walk steps left

  // held-back release
  logic               pend_r, pend_nxt;
  logic [ID_BITS-1:0] pend_id_r, pend_id_nxt;

  // output register
  logic               ov_r, ov_nxt;
  logic [1:0]         ost_r, ost_nxt;
  logic               orv_r, orv_nxt;
  logic [ID_BITS-1:0] oid_r, oid_nxt;
  logic               olast_r, olast_nxt;

  entry_t    cell_q [TABLE_DEPTH];
  cell_ctl_t ctl    [TABLE_DEPTH];
  entry_t    new_e, loop_e, head_e;
  logic      do_ins, do_adv;

  logic                 slot_free;
  logic                 in_acc;
  logic [TIME_BITS-1:0] head_cnt;
  logic                 head_rel;
  logic [CNT_W-1:0]     tail_idx;

  assign slot_free = !ov_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && slot_free;
  assign in_acc    = in_tvalid && in_tready;

  assign new_e.used   = 1'b1;
  assign new_e.id     = in_tdata[ID_BITS-1:0];
  assign new_e.cnt    = in_tdata[8 +: TIME_BITS];
  assign new_e.credit = in_tdata[24];

  // head step: saturating decrement, release test on the new count
  assign head_e   = cell_q[0];
  assign head_cnt = (head_e.cnt == '0) ? head_e.cnt : head_e.cnt - TIME_BITS'(1);
  assign head_rel = head_e.credit && (head_cnt == '0);

  assign loop_e.used   = !head_rel;
  assign loop_e.id     = head_e.id;
  assign loop_e.cnt    = head_cnt;
  assign loop_e.credit = head_e.credit;

  assign tail_idx = fill_r - CNT_W'(1);

  generate
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      entry_t prev_e, next_e;
      if (i == 0) begin : g_head
        assign prev_e = new_e;
      end else begin : g_mid
        assign prev_e = cell_q[i-1];
      end
      if (i == TABLE_DEPTH - 1) begin : g_tail
        assign next_e = '0;
      end else begin : g_body
        assign next_e = cell_q[i+1];
      end
      assign ctl[i].ins  = do_ins;
      assign ctl[i].adv  = do_adv;
      assign ctl[i].tail = (CNT_W'(i) == tail_idx);

      bpct_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl[i]),
        .prev_e (prev_e),
        .next_e (next_e),
        .loop_e (loop_e),
        .q      (cell_q[i])
      );
    end
  endgenerate

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    steps_nxt   = steps_r;
    pend_nxt    = pend_r;
    pend_id_nxt = pend_id_r;
    do_ins      = 1'b0;
    do_adv      = 1'b0;

    ov_nxt    = ov_r && !out_tready;
    ost_nxt   = ost_r;
    orv_nxt   = orv_r;
    oid_nxt   = oid_r;
    olast_nxt = olast_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == OP_BLOCK) begin
            ov_nxt    = 1'b1;
            orv_nxt   = 1'b0;
            oid_nxt   = '0;
            olast_nxt = 1'b1;
            if (fill_r == CNT_W'(TABLE_DEPTH)) begin
              ost_nxt = ST_FULL;
            end else begin
              ost_nxt  = ST_ACCEPT;
              do_ins   = 1'b1;
              fill_nxt = fill_r + CNT_W'(1);
            end
          end else begin
            pend_nxt  = 1'b0;
            steps_nxt = fill_r;
            state_nxt = (fill_r == '0) ? S_FLUSH : S_WALK;
          end
        end
      end
      S_WALK: begin
        if (slot_free) begin
          do_adv = 1'b1;
          if (head_rel) begin
            fill_nxt    = fill_r - CNT_W'(1);
            pend_nxt    = 1'b1;
            pend_id_nxt = head_e.id;
            if (pend_r) begin
              ov_nxt    = 1'b1;
              ost_nxt   = ST_TICK;
              orv_nxt   = 1'b1;
              oid_nxt   = pend_id_r;
              olast_nxt = 1'b0;
            end
          end
          steps_nxt = steps_r - CNT_W'(1);
          if (steps_r == CNT_W'(1)) begin
            state_nxt = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ost_nxt   = ST_TICK;
          orv_nxt   = pend_r;
          oid_nxt   = pend_r ? pend_id_r : '0;
          olast_nxt = 1'b1;
          pend_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      steps_r <= '0;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      steps_r <= steps_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
    pend_id_r <= pend_id_nxt;
    ost_r     <= ost_nxt;
    orv_r     <= orv_nxt;
    oid_r     <= oid_nxt;
    olast_r   <= olast_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = 8'(oid_r);
  assign out_tuser  = {orv_r, ost_r};
  assign out_tlast  = olast_r;

endmodule

// File: design/bpct_cell.sv
`timescale 1ns / 1ps

module bpct_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  bpct_pkg::cell_ctl_t ctl,
  input  bpct_pkg::entry_t   prev_e,
  input  bpct_pkg::entry_t   next_e,
  input  bpct_pkg::entry_t   loop_e,
  output bpct_pkg::entry_t   q
);
  import bpct_pkg::*;

  entry_t e_r, e_nxt;

  always_comb begin
    e_nxt = e_r;
    if (ctl.ins) begin
      e_nxt = prev_e;
    end else if (ctl.adv) begin
      e_nxt = ctl.tail ? loop_e : next_e;
    end
  end

  // only the used flag is control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_r.used <= 1'b0;
    end else begin
      e_r.used <= e_nxt.used;
    end
    e_r.id     <= e_nxt.id;
    e_r.cnt    <= e_nxt.cnt;
    e_r.credit <= e_nxt.credit;
  end

  assign q = e_r;

endmodule
